[hw/rtl/lrpa_pkg.sv]
// Shared types and constants for the line rasterizer with pixel address.
`timescale 1ns / 1ps
package lrpa_pkg;

    // Port field widths
    localparam int XY_W       = 16;
    localparam int COLOR_W    = 32;
    localparam int OFF_W      = 26;
    localparam int ROW_W      = 16;
    localparam int BPP_W      = 3;

    // Window coordinates fit in 14 bits once a pixel is visible
    localparam int IDX_W      = 14;

    // Width for signed window compares, wide enough for any coordinate and screen size
    localparam int CMP_W      = 18;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register select, taken from byte address bit 2
    localparam logic REG_ROW_BYTES       = 1'b0;
    localparam logic REG_BYTES_PER_PIXEL = 1'b1;

    // Reset values of the configuration registers
    localparam logic [ROW_W-1:0] ROW_BYTES_RST = 16'd4096;
    localparam logic [BPP_W-1:0] BPP_RST       = 3'd4;

    // Item opcodes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

    // Per-beat control into the line walker
    typedef struct packed {
        logic load;    // load beat accepted
        logic step;    // step beat accepted
    } walk_ctrl_t;

endpackage

[hw/rtl/lrpa_cfg.sv]
// APB configuration registers: row pitch and bytes per pixel.
`timescale 1ns / 1ps
module lrpa_cfg
    import lrpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [ROW_W-1:0]      row_bytes,
    output logic [BPP_W-1:0]      bytes_per_pixel
);

    logic [ROW_W-1:0] row_bytes_reg;
    logic [ROW_W-1:0] row_bytes_next;
    logic [BPP_W-1:0] bpp_reg;
    logic [BPP_W-1:0] bpp_next;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    // Decode the write beat
    always_comb
    begin
        row_bytes_next = row_bytes_reg;
        bpp_next       = bpp_reg;
        if (wr_en)
        begin
            case (reg_sel)
                REG_ROW_BYTES:       row_bytes_next = pwdata[ROW_W-1:0];
                REG_BYTES_PER_PIXEL: bpp_next       = pwdata[BPP_W-1:0];
                default:             row_bytes_next = row_bytes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_BYTES_RST;
            bpp_reg       <= BPP_RST;
        end
        else
        begin
            row_bytes_reg <= row_bytes_next;
            bpp_reg       <= bpp_next;
        end
    end

    // Return the selected register
    always_comb
    begin
        case (reg_sel)
            REG_ROW_BYTES:       prdata = {{(APB_DATA_W-ROW_W){1'b0}}, row_bytes_reg};
            REG_BYTES_PER_PIXEL: prdata = {{(APB_DATA_W-BPP_W){1'b0}}, bpp_reg};
            default:             prdata = '0;
        endcase
    end

    assign row_bytes       = row_bytes_reg;
    assign bytes_per_pixel = bpp_reg;

endmodule

[hw/rtl/lrpa_setup.sv]
// Line setup: trivial rejection, deltas, step directions and initial error.
`timescale 1ns / 1ps
module lrpa_setup
    import lrpa_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int COORD_BITS    = 16
)
(
    input  logic [XY_W-1:0]              start_x,
    input  logic [XY_W-1:0]              start_y,
    input  logic [XY_W-1:0]              end_x,
    input  logic [XY_W-1:0]              end_y,
    output logic                         reject,
    output logic signed [COORD_BITS-1:0] x0,
    output logic signed [COORD_BITS-1:0] y0,
    output logic signed [COORD_BITS-1:0] x1,
    output logic signed [COORD_BITS-1:0] y1,
    output logic signed [COORD_BITS:0]   dx,
    output logic signed [COORD_BITS:0]   dyn,
    output logic                         sx_neg,
    output logic                         sy_neg,
    output logic signed [COORD_BITS+2:0] err0
);

    localparam int D_W = COORD_BITS + 1;
    localparam int E_W = COORD_BITS + 3;

    localparam logic signed [CMP_W-1:0] WIN_W = CMP_W'(SCREEN_WIDTH);
    localparam logic signed [CMP_W-1:0] WIN_H = CMP_W'(SCREEN_HEIGHT);

    logic signed [CMP_W-1:0] x0_e;
    logic signed [CMP_W-1:0] y0_e;
    logic signed [CMP_W-1:0] x1_e;
    logic signed [CMP_W-1:0] y1_e;
    logic signed [D_W-1:0]   diff_x;
    logic signed [D_W-1:0]   diff_y;

    // Keep the low coordinate bits, sign taken from the top kept bit
    assign x0 = start_x[COORD_BITS-1:0];
    assign y0 = start_y[COORD_BITS-1:0];
    assign x1 = end_x[COORD_BITS-1:0];
    assign y1 = end_y[COORD_BITS-1:0];

    assign x0_e = CMP_W'(x0);
    assign y0_e = CMP_W'(y0);
    assign x1_e = CMP_W'(x1);
    assign y1_e = CMP_W'(y1);

    // Drop a line lying wholly beyond one window edge
    assign reject = (x0_e[CMP_W-1] && x1_e[CMP_W-1]) ||
                    (x0_e >= WIN_W && x1_e >= WIN_W) ||
                    (y0_e[CMP_W-1] && y1_e[CMP_W-1]) ||
                    (y0_e >= WIN_H && y1_e >= WIN_H);

    // Deltas: dx positive, dy kept negative
    assign diff_x = D_W'(x1) - D_W'(x0);
    assign diff_y = D_W'(y1) - D_W'(y0);
    assign dx     = diff_x[D_W-1] ? -diff_x : diff_x;
    assign dyn    = diff_y[D_W-1] ? diff_y : -diff_y;
    assign sx_neg = !(x0 < x1);
    assign sy_neg = !(y0 < y1);
    assign err0   = E_W'(dx) + E_W'(dyn);

endmodule

[hw/rtl/lrpa_walk.sv]
// Line walker: holds the active line and advances it one pixel per step beat.
`timescale 1ns / 1ps
module lrpa_walk
    import lrpa_pkg::*;
#(
    parameter int COORD_BITS = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  walk_ctrl_t                   ctrl,
    input  logic                         reject,
    input  logic signed [COORD_BITS-1:0] x0,
    input  logic signed [COORD_BITS-1:0] y0,
    input  logic signed [COORD_BITS-1:0] x1,
    input  logic signed [COORD_BITS-1:0] y1,
    input  logic signed [COORD_BITS:0]   dx,
    input  logic signed [COORD_BITS:0]   dyn,
    input  logic                         sx_neg,
    input  logic                         sy_neg,
    input  logic signed [COORD_BITS+2:0] err0,
    input  logic [COLOR_W-1:0]           color,
    output logic                         active,
    output logic                         fin,
    output logic signed [COORD_BITS-1:0] cur_x,
    output logic signed [COORD_BITS-1:0] cur_y,
    output logic [COLOR_W-1:0]           line_color
);

    localparam int D_W = COORD_BITS + 1;
    localparam int E_W = COORD_BITS + 3;

    logic                         active_reg, active_next;
    logic signed [COORD_BITS-1:0] cur_x_reg, cur_x_next;
    logic signed [COORD_BITS-1:0] cur_y_reg, cur_y_next;
    logic signed [COORD_BITS-1:0] goal_x_reg, goal_x_next;
    logic signed [COORD_BITS-1:0] goal_y_reg, goal_y_next;
    logic signed [D_W-1:0]        dx_reg, dx_next;
    logic signed [D_W-1:0]        dyn_reg, dyn_next;
    logic                         sx_neg_reg, sx_neg_next;
    logic                         sy_neg_reg, sy_neg_next;
    logic signed [E_W-1:0]        err_reg, err_next;
    logic [COLOR_W-1:0]           color_reg, color_next;

    logic signed [E_W:0]          e2;
    logic                         move_x;
    logic                         move_y;
    logic signed [E_W-1:0]        add_x;
    logic signed [E_W-1:0]        add_y;

    assign fin = (cur_x_reg == goal_x_reg) && (cur_y_reg == goal_y_reg);

    // Bresenham decision on doubled error
    assign e2     = {err_reg, 1'b0};
    assign move_x = e2 >= (E_W+1)'(dyn_reg);
    assign move_y = e2 <= (E_W+1)'(dx_reg);
    assign add_x  = move_x ? E_W'(dyn_reg) : '0;
    assign add_y  = move_y ? E_W'(dx_reg) : '0;

    // Load a new line or advance the current one
    always_comb
    begin
        active_next = active_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        dx_next     = dx_reg;
        dyn_next    = dyn_reg;
        sx_neg_next = sx_neg_reg;
        sy_neg_next = sy_neg_reg;
        err_next    = err_reg;
        color_next  = color_reg;
        if (ctrl.load)
        begin
            active_next = !reject;
            cur_x_next  = x0;
            cur_y_next  = y0;
            goal_x_next = x1;
            goal_y_next = y1;
            dx_next     = dx;
            dyn_next    = dyn;
            sx_neg_next = sx_neg;
            sy_neg_next = sy_neg;
            err_next    = err0;
            color_next  = color;
        end
        else if (ctrl.step && active_reg)
        begin
            if (fin)
            begin
                active_next = 1'b0;
            end
            else
            begin
                if (move_x)
                begin
                    cur_x_next = sx_neg_reg ? cur_x_reg - COORD_BITS'(1)
                                            : cur_x_reg + COORD_BITS'(1);
                end
                if (move_y)
                begin
                    cur_y_next = sy_neg_reg ? cur_y_reg - COORD_BITS'(1)
                                            : cur_y_reg + COORD_BITS'(1);
                end
                err_next = err_reg + add_x + add_y;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    // Line geometry needs no reset: it is read only while active
    always_ff @(posedge clk)
    begin
        cur_x_reg  <= cur_x_next;
        cur_y_reg  <= cur_y_next;
        goal_x_reg <= goal_x_next;
        goal_y_reg <= goal_y_next;
        dx_reg     <= dx_next;
        dyn_reg    <= dyn_next;
        sx_neg_reg <= sx_neg_next;
        sy_neg_reg <= sy_neg_next;
        err_reg    <= err_next;
        color_reg  <= color_next;
    end

    assign active     = active_reg;
    assign cur_x      = cur_x_reg;
    assign cur_y      = cur_y_reg;
    assign line_color = color_reg;

endmodule

[hw/rtl/lrpa_pixel.sv]
// Pixel address: window test and framebuffer byte offset of the current pixel.
`timescale 1ns / 1ps
module lrpa_pixel
    import lrpa_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int COORD_BITS    = 16
)
(
    input  logic signed [COORD_BITS-1:0] cur_x,
    input  logic signed [COORD_BITS-1:0] cur_y,
    input  logic [ROW_W-1:0]             row_bytes,
    input  logic [BPP_W-1:0]             bytes_per_pixel,
    output logic                         visible,
    output logic [OFF_W-1:0]             byte_offset
);

    localparam int ROWP_W = IDX_W + ROW_W;
    localparam int COLP_W = IDX_W + BPP_W;

    localparam logic signed [CMP_W-1:0] WIN_W = CMP_W'(SCREEN_WIDTH);
    localparam logic signed [CMP_W-1:0] WIN_H = CMP_W'(SCREEN_HEIGHT);

    logic signed [CMP_W-1:0] x_e;
    logic signed [CMP_W-1:0] y_e;
    logic [IDX_W-1:0]        x_idx;
    logic [IDX_W-1:0]        y_idx;
    logic [ROWP_W-1:0]       row_part;
    logic [COLP_W-1:0]       col_part;
    logic [OFF_W-1:0]        sum;

    assign x_e = CMP_W'(cur_x);
    assign y_e = CMP_W'(cur_y);

    // Inside the window on both axes
    assign visible = !x_e[CMP_W-1] && (x_e < WIN_W) &&
                     !y_e[CMP_W-1] && (y_e < WIN_H);

    // Row pitch times y plus pixel size times x, wrapped to the offset width
    assign x_idx    = IDX_W'(cur_x);
    assign y_idx    = IDX_W'(cur_y);
    assign row_part = ROWP_W'(y_idx) * ROWP_W'(row_bytes);
    assign col_part = COLP_W'(x_idx) * COLP_W'(bytes_per_pixel);
    assign sum      = OFF_W'(row_part) + OFF_W'(col_part);

    assign byte_offset = visible ? sum : '0;

endmodule

[hw/rtl/line_rasterizer_with_pixel_address_top.sv]
// Top level of the line rasterizer with pixel address generation.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready) carries one beat per item. A load beat
//   (op = 0) latches two endpoints and a color; a line lying wholly past one
//   window edge is dropped and leaves the block idle. A step beat (op = 1)
//   emits the current pixel of the active line and advances it; a step with
//   no active line is consumed and emits nothing. Loads never emit a beat.
//   Output channel (out_valid/out_ready) carries pix_x, pix_y, visible,
//   byte_offset (zero when not visible), pixel_color and last, which marks
//   the end pixel of the line, after which the line is closed.
//   An accepted step beat's pixel is registered and shows in the next cycle.
//   Throughput: one item per cycle while the output is not stalled, set by
//   the single registered pass through the walker and the offset multiplier.
//   The output register holds its beat while out_ready is low; a new item
//   is taken in the same cycle that the waiting beat leaves, so a stall
//   only stops the input while the output register is full.
//   Reset clears the active line and the output valid, and sets row_bytes
//   to 4096 and bytes_per_pixel to 4. The APB registers lie at byte
//   addresses 0 (row_bytes) and 4 (bytes_per_pixel); write them only idle.
module line_rasterizer_with_pixel_address_top
    import lrpa_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 1024,
    parameter int SCREEN_HEIGHT = 768,
    parameter int COORD_BITS    = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [XY_W-1:0]       start_x,
    input  logic [XY_W-1:0]       start_y,
    input  logic [XY_W-1:0]       end_x,
    input  logic [XY_W-1:0]       end_y,
    input  logic [COLOR_W-1:0]    color,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [XY_W-1:0]       pix_x,
    output logic [XY_W-1:0]       pix_y,
    output logic                  visible,
    output logic [OFF_W-1:0]      byte_offset,
    output logic [COLOR_W-1:0]    pixel_color,
    output logic                  last
);

    logic [ROW_W-1:0]             row_bytes;
    logic [BPP_W-1:0]             bytes_per_pixel;

    logic                         reject;
    logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
    logic signed [COORD_BITS:0]   dx, dyn;
    logic                         sx_neg, sy_neg;
    logic signed [COORD_BITS+2:0] err0;

    walk_ctrl_t                   ctrl;
    logic                         accept;
    logic                         emit;
    logic                         active;
    logic                         fin;
    logic signed [COORD_BITS-1:0] cur_x, cur_y;
    logic [COLOR_W-1:0]           line_color;
    logic                         pix_visible;
    logic [OFF_W-1:0]             pix_offset;

    logic                         out_valid_reg, out_valid_next;
    logic [XY_W-1:0]              pix_x_reg, pix_y_reg;
    logic                         visible_reg;
    logic [OFF_W-1:0]             offset_reg;
    logic [COLOR_W-1:0]           color_reg;
    logic                         last_reg;

    lrpa_cfg u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .row_bytes       (row_bytes),
        .bytes_per_pixel (bytes_per_pixel)
    );

    lrpa_setup #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .COORD_BITS    (COORD_BITS)
    ) u_setup (
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .reject  (reject),
        .x0      (x0),
        .y0      (y0),
        .x1      (x1),
        .y1      (y1),
        .dx      (dx),
        .dyn     (dyn),
        .sx_neg  (sx_neg),
        .sy_neg  (sy_neg),
        .err0    (err0)
    );

    // Accept whenever the output register is empty or draining
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign ctrl.load = accept && (op == OP_LOAD);
    assign ctrl.step = accept && (op == OP_STEP);
    assign emit      = ctrl.step && active;

    lrpa_walk #(
        .COORD_BITS (COORD_BITS)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .reject     (reject),
        .x0         (x0),
        .y0         (y0),
        .x1         (x1),
        .y1         (y1),
        .dx         (dx),
        .dyn        (dyn),
        .sx_neg     (sx_neg),
        .sy_neg     (sy_neg),
        .err0       (err0),
        .color      (color),
        .active     (active),
        .fin        (fin),
        .cur_x      (cur_x),
        .cur_y      (cur_y),
        .line_color (line_color)
    );

    lrpa_pixel #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .COORD_BITS    (COORD_BITS)
    ) u_pixel (
        .cur_x           (cur_x),
        .cur_y           (cur_y),
        .row_bytes       (row_bytes),
        .bytes_per_pixel (bytes_per_pixel),
        .visible         (pix_visible),
        .byte_offset     (pix_offset)
    );

    // Fill the output register on an emitted pixel, drain it when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the pixel beat
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            pix_x_reg   <= XY_W'(cur_x);
            pix_y_reg   <= XY_W'(cur_y);
            visible_reg <= pix_visible;
            offset_reg  <= pix_offset;
            color_reg   <= line_color;
            last_reg    <= fin;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pix_x       = pix_x_reg;
    assign pix_y       = pix_y_reg;
    assign visible     = visible_reg;
    assign byte_offset = offset_reg;
    assign pixel_color = color_reg;
    assign last        = last_reg;

`ifndef NO_ASSERTIONS
    // Input stalls only behind a full, stalled output register
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("in_ready low without a stalled output beat");

    // An emitted pixel shows on the output next cycle
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> out_valid)
        else $error("emitted pixel missing from the output");

    // The end pixel closes the line
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && fin) |=> !active)
        else $error("line still active after its end pixel");

    // Hidden pixels carry a zero offset
    a_hidden_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !visible) |-> (byte_offset == '0))
        else $error("nonzero offset on a hidden pixel");

    // A step with no line leaves the output untouched unless it drains
    a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.step && !active && out_ready) |=> !out_valid)
        else $error("step without a line produced a beat");
`endif

endmodule

[bench/tb.sv]
// Self-checking testbench for the line rasterizer with pixel address generation.
`timescale 1ns / 1ps
module tb;
    import lrpa_pkg::*;

    localparam int SCREEN_W = 1024;
    localparam int SCREEN_H = 768;

    // One expected output beat
    typedef struct packed {
        logic [XY_W-1:0]    px;
        logic [XY_W-1:0]    py;
        logic               vis;
        logic [OFF_W-1:0]   off;
        logic [COLOR_W-1:0] col;
        logic               fin;
    } pixel_t;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_ready;
    logic                  op;
    logic [XY_W-1:0]       start_x;
    logic [XY_W-1:0]       start_y;
    logic [XY_W-1:0]       end_x;
    logic [XY_W-1:0]       end_y;
    logic [COLOR_W-1:0]    color;
    logic                  out_valid;
    logic                  out_ready;
    logic [XY_W-1:0]       pix_x;
    logic [XY_W-1:0]       pix_y;
    logic                  visible;
    logic [OFF_W-1:0]      byte_offset;
    logic [COLOR_W-1:0]    pixel_color;
    logic                  last;

    // Predicted walker state and register copies
    logic                  line_on;
    logic signed [XY_W-1:0] walk_x;
    logic signed [XY_W-1:0] walk_y;
    logic signed [XY_W-1:0] goal_x;
    logic signed [XY_W-1:0] goal_y;
    int                    span_x;
    int                    span_y_neg;
    int                    dir_x;
    int                    dir_y;
    int                    walk_err;
    logic [COLOR_W-1:0]    line_col;
    logic [ROW_W-1:0]      cfg_row;
    logic [BPP_W-1:0]      cfg_bpp;

    pixel_t                exp_pixels[$];
    pixel_t                want;
    int                    fail_count;
    int                    items_sent;
    int                    stall_left;
    bit                    idle_en;

    line_rasterizer_with_pixel_address_top #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H),
        .COORD_BITS    (16)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .color       (color),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pix_x       (pix_x),
        .pix_y       (pix_y),
        .visible     (visible),
        .byte_offset (byte_offset),
        .pixel_color (pixel_color),
        .last        (last)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Advance the line model by one accepted beat
    task automatic walk_predict(input op_t o, input logic [XY_W-1:0] sx, input logic [XY_W-1:0] sy,
                                input logic [XY_W-1:0] ex, input logic [XY_W-1:0] ey,
                                input logic [COLOR_W-1:0] col);
        int x0;
        int y0;
        int x1;
        int y1;
        int e2;
        longint unsigned off64;
        pixel_t p;
        if (o == OP_LOAD)
        begin
            x0 = int'($signed(sx));
            y0 = int'($signed(sy));
            x1 = int'($signed(ex));
            y1 = int'($signed(ey));
            if ((x0 < 0 && x1 < 0) || (x0 >= SCREEN_W && x1 >= SCREEN_W) ||
                (y0 < 0 && y1 < 0) || (y0 >= SCREEN_H && y1 >= SCREEN_H))
            begin
                line_on = 1'b0;
            end
            else
            begin
                walk_x     = sx;
                walk_y     = sy;
                goal_x     = ex;
                goal_y     = ey;
                span_x     = (x1 > x0) ? x1 - x0 : x0 - x1;
                span_y_neg = (y1 > y0) ? y0 - y1 : y1 - y0;
                dir_x      = (x0 < x1) ? 1 : -1;
                dir_y      = (y0 < y1) ? 1 : -1;
                walk_err   = span_x + span_y_neg;
                line_col   = col;
                line_on    = 1'b1;
            end
        end
        else if (line_on)
        begin
            p.px  = walk_x;
            p.py  = walk_y;
            p.vis = (walk_x >= 0) && (walk_x < SCREEN_W) && (walk_y >= 0) && (walk_y < SCREEN_H);
            off64 = longint'(walk_y) * longint'(cfg_row) + longint'(walk_x) * longint'(cfg_bpp);
            p.off = p.vis ? off64[OFF_W-1:0] : '0;
            p.col = line_col;
            p.fin = (walk_x == goal_x) && (walk_y == goal_y);
            exp_pixels.push_back(p);
            if (p.fin)
            begin
                line_on = 1'b0;
            end
            else
            begin
                e2 = 2 * walk_err;
                if (e2 >= span_y_neg)
                begin
                    walk_x   = XY_W'(walk_x + dir_x);
                    walk_err = walk_err + span_y_neg;
                end
                if (e2 <= span_x)
                begin
                    walk_y   = XY_W'(walk_y + dir_y);
                    walk_err = walk_err + span_x;
                end
            end
        end
    endtask

    // Present one beat, hold it until accepted, then predict
    task automatic send_item(input op_t o, input logic [XY_W-1:0] sx, input logic [XY_W-1:0] sy,
                             input logic [XY_W-1:0] ex, input logic [XY_W-1:0] ey,
                             input logic [COLOR_W-1:0] col);
        int gap;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op       <= o;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        color    <= col;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        walk_predict(o, sx, sy, ex, ey, col);
        items_sent++;
    endtask

    task automatic send_load(input logic [XY_W-1:0] sx, input logic [XY_W-1:0] sy,
                             input logic [XY_W-1:0] ex, input logic [XY_W-1:0] ey,
                             input logic [COLOR_W-1:0] col);
        send_item(OP_LOAD, sx, sy, ex, ey, col);
    endtask

    // Step beats carry random payload, which the block ignores
    task automatic send_step();
        send_item(OP_STEP, XY_W'($urandom), XY_W'($urandom), XY_W'($urandom),
                  XY_W'($urandom), $urandom);
    endtask

    task automatic walk_to_end();
        while (line_on) send_step();
    endtask

    // Drop valid and wait until every predicted pixel has left the block
    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (exp_pixels.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] d);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= a;
        pwdata  <= d;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (a[2] == REG_ROW_BYTES)
            cfg_row = d[ROW_W-1:0];
        else
            cfg_bpp = d[BPP_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_read_check(input logic [APB_ADDR_W-1:0] a, input logic [APB_DATA_W-1:0] exp);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= a;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        if (prdata !== exp)
        begin
            $display("%0t register read at %0d: expected %h actual %h", $time, a, exp, prdata);
            fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Reprogram both registers once idle; upper data bits carry junk
    task automatic set_config(input logic [ROW_W-1:0] row, input logic [BPP_W-1:0] bpp);
        logic [31:0] junk;
        drain_pixels();
        junk = $urandom;
        apb_write({REG_ROW_BYTES, 2'b00}, {junk[31:16], row});
        apb_write({REG_BYTES_PER_PIXEL, 2'b00}, {junk[28:0], bpp});
        apb_read_check({REG_ROW_BYTES, 2'b00}, {16'd0, row});
        apb_read_check({REG_BYTES_PER_PIXEL, 2'b00}, {29'd0, bpp});
    endtask

    // Mostly short lines around the window walked to the end, some cut
    // short, some full-range noise loads, and stray steps with no line
    task automatic run_line_mix(input int n_items);
        int stop_at;
        int x0;
        int y0;
        int x1;
        int y1;
        int span;
        int kind;
        int k;
        int limit;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 10)
            begin
                send_load(XY_W'($urandom), XY_W'($urandom), XY_W'($urandom),
                          XY_W'($urandom), $urandom);
                limit = $urandom_range(0, 5);
            end
            else
            begin
                span = ($urandom_range(0, 19) == 0) ? 400 : int'($urandom_range(0, 24));
                x0 = int'($urandom_range(0, SCREEN_W + 79)) - 40;
                y0 = int'($urandom_range(0, SCREEN_H + 79)) - 40;
                x1 = x0 + int'($urandom_range(0, 2 * span)) - span;
                y1 = y0 + int'($urandom_range(0, 2 * span)) - span;
                send_load(x0[XY_W-1:0], y0[XY_W-1:0], x1[XY_W-1:0], y1[XY_W-1:0], $urandom);
                limit = (kind < 20) ? int'($urandom_range(0, span)) : 1000;
            end
            k = 0;
            while (line_on && k < limit)
            begin
                send_step();
                k++;
            end
            if ($urandom_range(0, 9) == 0)
                send_step();
        end
    endtask

    task automatic test_reset_values();
        apb_read_check({REG_ROW_BYTES, 2'b00}, {16'd0, ROW_BYTES_RST});
        apb_read_check({REG_BYTES_PER_PIXEL, 2'b00}, {29'd0, BPP_RST});
    endtask

    task automatic test_idle_step();
        send_step();
    endtask

    task automatic test_single_point();
        send_load(16'd1023, 16'd767, 16'd1023, 16'd767, 32'hFFFF_FFFF);
        send_step();
        send_step();
    endtask

    // Extreme corners, then a load that replaces the active line
    task automatic test_extreme_coords();
        send_load(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 32'h0000_0000);
        send_step();
        send_step();
        send_load(16'd0, 16'd0, 16'd2, 16'd1, 32'hA5A5_5A5A);
        walk_to_end();
    endtask

    // Each outer side rejects; a reject also drops the active line
    task automatic test_rejects();
        send_load(16'd5, 16'd5, 16'd8, 16'd8, 32'h1234_5678);
        send_step();
        send_load(16'h8000, 16'd5, 16'hFFFF, 16'd9, 32'h1);
        send_load(16'd1024, 16'd5, 16'h7FFF, 16'd9, 32'h2);
        send_load(16'd5, 16'h8000, 16'd9, 16'hFFFF, 32'h3);
        send_load(16'd5, 16'd768, 16'd9, 16'h7FFF, 32'h4);
        send_step();
    endtask

    task automatic test_config_extremes();
        set_config(16'd0, 3'd1);
        send_load(16'd5, 16'd7, 16'd9, 16'd8, 32'hDEAD_BEEF);
        walk_to_end();
        set_config(16'hFFFF, 3'd7);
        send_load(16'd1023, 16'd767, 16'd1020, 16'd765, 32'h0F0F_0F0F);
        walk_to_end();
        set_config(ROW_W'($urandom), 3'd0);
        send_load(16'd3, 16'd3, 16'd0, 16'd0, 32'h8000_0001);
        walk_to_end();
    endtask

    task automatic test_random_lines();
        logic [ROW_W-1:0] rows[6];
        logic [BPP_W-1:0] bpps[6];
        rows = '{16'd4096, 16'hFFFF, 16'd0, 16'd1, 16'd2560, 16'd0};
        bpps = '{3'd4, 3'd1, 3'd7, 3'd3, 3'd5, 3'd2};
        for (int i = 0; i < 6; i++)
        begin
            if (i == 5)
                set_config(ROW_W'($urandom), BPP_W'($urandom));
            else
                set_config(rows[i], bpps[i]);
            run_line_mix(250);
        end
    endtask

    task automatic test_no_idle_tail();
        set_config(16'd4096, 3'd4);
        idle_en = 1'b0;
        run_line_mix(300);
        drain_pixels();
    endtask

    // Random output stalls in bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (idle_en && $urandom_range(0, 11) == 0)
        begin
            stall_left = $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act)
        begin
            $display("%0t %s: expected %h actual %h", $time, name, exp, act);
            fail_count++;
        end
    endtask

    // Compare each output beat with the oldest predicted pixel
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (exp_pixels.size() == 0)
            begin
                $display("%0t unexpected beat: expected none actual x=%h y=%h", $time, pix_x, pix_y);
                fail_count++;
            end
            else
            begin
                want = exp_pixels.pop_front();
                check_field("pix_x", 32'(want.px), 32'(pix_x));
                check_field("pix_y", 32'(want.py), 32'(pix_y));
                check_field("visible", 32'(want.vis), 32'(visible));
                check_field("byte_offset", 32'(want.off), 32'(byte_offset));
                check_field("pixel_color", want.col, pixel_color);
                check_field("last", 32'(want.fin), 32'(last));
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        rst_n      = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        in_valid   = 1'b0;
        op         = OP_LOAD;
        start_x    = '0;
        start_y    = '0;
        end_x      = '0;
        end_y      = '0;
        color      = '0;
        out_ready  = 1'b1;
        line_on    = 1'b0;
        walk_x     = '0;
        walk_y     = '0;
        goal_x     = '0;
        goal_y     = '0;
        span_x     = 0;
        span_y_neg = 0;
        dir_x      = 0;
        dir_y      = 0;
        walk_err   = 0;
        line_col   = '0;
        cfg_row    = ROW_BYTES_RST;
        cfg_bpp    = BPP_RST;
        fail_count = 0;
        items_sent = 0;
        stall_left = 0;
        idle_en    = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_idle_step();
        test_single_point();
        test_extreme_coords();
        test_rejects();
        test_config_extremes();
        test_random_lines();
        test_no_idle_tail();

        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
